>>> hw/rtl/cdb_pkg.sv
package cdb_pkg;

  localparam int ROWS_DEF = 2;
  localparam int COLS_DEF = 20;

  localparam int ACTION_W     = 4;
  localparam int CHAR_W       = 8;
  localparam int TGT_ROW_W    = 3;
  localparam int TGT_COL_W    = 5;
  localparam int CURSOR_COL_W = 5;

  localparam logic [ACTION_W-1:0] ACT_WRITE      = 4'd0;
  localparam logic [ACTION_W-1:0] ACT_CLEAR      = 4'd1;
  localparam logic [ACTION_W-1:0] ACT_CLEAR_EOL  = 4'd2;
  localparam logic [ACTION_W-1:0] ACT_UP         = 4'd3;
  localparam logic [ACTION_W-1:0] ACT_DOWN       = 4'd4;
  localparam logic [ACTION_W-1:0] ACT_LEFT       = 4'd5;
  localparam logic [ACTION_W-1:0] ACT_RIGHT      = 4'd6;
  localparam logic [ACTION_W-1:0] ACT_SET_POS    = 4'd7;
  localparam logic [ACTION_W-1:0] ACT_SHIFT_LEFT = 4'd8;
  localparam logic [ACTION_W-1:0] ACT_READ       = 4'd9;

  localparam logic [CHAR_W-1:0] FIRST_PRINTABLE = 8'h20;
  localparam logic [CHAR_W-1:0] LAST_PRINTABLE  = 8'h7E;

  typedef logic [CURSOR_COL_W-1:0] col_field_t;

  typedef struct packed {
    logic [ACTION_W-1:0]  action;
    logic [CHAR_W-1:0]    char_code;
    logic [TGT_ROW_W-1:0] target_row;
    logic [TGT_COL_W-1:0] target_col;
  } in_item_t;

  typedef struct packed {
    logic              ok;
    logic              cursor_row;
    col_field_t        cursor_col;
    logic [CHAR_W-1:0] cell_char;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EOL,
    ST_SHIFT
  } state_t;

endpackage

>>> hw/rtl/char_display_buffer_cursor_core.sv
// Character display buffer of ROWS x COLS 8-bit cells with a cursor. Write,
// clear, cursor moves and set position finish in the cycle the item is
// transferred, the result appearing on the output register in the cycle
// after. Read passes through the registered memory read and the ST_READ
// state. Clear to end of line and shift left step one address counter
// through the cell memory, one cell per cycle, over its single write port.
// in_ready is low while an item is in work or a finished result is waiting
// and not being taken. Cells read as zero after reset and after clear
// through per-cell valid flops, so no clearing pass is needed.
module char_display_buffer_cursor_core #(
  parameter int ROWS = cdb_pkg::ROWS_DEF,
  parameter int COLS = cdb_pkg::COLS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  cdb_pkg::in_item_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output cdb_pkg::out_item_t out_data
);
  import cdb_pkg::*;

  localparam int NCELLS = ROWS * COLS;
  localparam int AW     = $clog2(NCELLS);
  localparam int RW     = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CW     = $clog2(COLS);

  localparam logic [AW-1:0] COLS_A    = AW'(COLS);
  localparam logic [AW-1:0] LAST_A    = AW'(NCELLS - 1);
  localparam logic [AW-1:0] PRELAST_A = AW'(NCELLS - 2);
  localparam logic [RW-1:0] LAST_ROW  = RW'(ROWS - 1);
  localparam logic [CW-1:0] LAST_COL  = CW'(COLS - 1);

  state_t state_r, state_nxt;

  logic [RW-1:0] cur_row_r, cur_row_nxt;
  logic [CW-1:0] cur_col_r, cur_col_nxt;
  logic [AW-1:0] ptr_r, ptr_nxt;

  logic [CHAR_W-1:0] mem [NCELLS];
  logic [NCELLS-1:0] vld_r;
  logic [CHAR_W-1:0] mem_rd_r;
  logic              rd_vld_r;

  logic              mem_we;
  logic [AW-1:0]     mem_wa;
  logic [CHAR_W-1:0] mem_wd;
  logic [AW-1:0]     rd_addr;
  logic              clr_all;

  logic              fin;
  logic              fin_ok;
  logic [CHAR_W-1:0] fin_cell;

  logic      out_valid_r;
  out_item_t out_data_r;

  logic              accept;
  logic              tgt_row_ok;
  logic              tgt_col_ok;
  logic              printable;
  logic [AW-1:0]     cur_idx;
  logic [AW-1:0]     tgt_idx;
  logic [AW-1:0]     eol_end;
  logic [CHAR_W-1:0] cell_rd;

  assign in_ready  = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign tgt_row_ok = in_data.target_row < 3'(ROWS);
  assign tgt_col_ok = {1'b0, in_data.target_col} < 6'(COLS);
  assign printable  = (in_data.char_code >= FIRST_PRINTABLE) &&
                      (in_data.char_code <= LAST_PRINTABLE);

  assign cur_idx = AW'(cur_row_r) * COLS_A + AW'(cur_col_r);
  assign tgt_idx = AW'(in_data.target_row) * COLS_A + AW'(in_data.target_col);
  assign eol_end = AW'(cur_row_r) * COLS_A + AW'(LAST_COL);
  assign cell_rd = rd_vld_r ? mem_rd_r : '0;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_data.action == ACT_CLEAR_EOL) begin
            state_nxt = ST_EOL;
          end else if (in_data.action == ACT_SHIFT_LEFT) begin
            state_nxt = ST_SHIFT;
          end else if (in_data.action == ACT_READ && tgt_row_ok && tgt_col_ok) begin
            state_nxt = ST_READ;
          end
        end
      end
      ST_READ:  state_nxt = ST_IDLE;
      ST_EOL:   if (ptr_r == eol_end) state_nxt = ST_IDLE;
      ST_SHIFT: if (ptr_r == LAST_A) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // datapath and sequencer outputs
  always_comb begin
    cur_row_nxt = cur_row_r;
    cur_col_nxt = cur_col_r;
    ptr_nxt     = ptr_r;
    mem_we      = 1'b0;
    mem_wa      = ptr_r;
    mem_wd      = '0;
    rd_addr     = ptr_r;
    clr_all     = 1'b0;
    fin         = 1'b0;
    fin_ok      = 1'b0;
    fin_cell    = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          fin = 1'b1;
          unique case (in_data.action)
            ACT_WRITE: begin
              if (printable) begin
                mem_we = 1'b1;
                mem_wa = cur_idx;
                mem_wd = in_data.char_code;
                fin_ok = 1'b1;
                if (cur_col_r != LAST_COL) begin
                  cur_col_nxt = cur_col_r + 1'b1;
                end else if (cur_row_r != LAST_ROW) begin
                  cur_row_nxt = cur_row_r + 1'b1;
                  cur_col_nxt = '0;
                end else begin
                  cur_row_nxt = '0;
                  cur_col_nxt = '0;
                end
              end
            end
            ACT_CLEAR: begin
              clr_all     = 1'b1;
              cur_row_nxt = '0;
              cur_col_nxt = '0;
              fin_ok      = 1'b1;
            end
            ACT_CLEAR_EOL: begin
              fin         = 1'b0;
              ptr_nxt     = cur_idx;
              cur_col_nxt = '0;
            end
            ACT_UP: begin
              if (cur_row_r != '0) begin
                cur_row_nxt = cur_row_r - 1'b1;
                fin_ok      = 1'b1;
              end
            end
            ACT_DOWN: begin
              if (cur_row_r != LAST_ROW) begin
                cur_row_nxt = cur_row_r + 1'b1;
                fin_ok      = 1'b1;
              end
            end
            ACT_LEFT: begin
              if (cur_col_r != '0) begin
                cur_col_nxt = cur_col_r - 1'b1;
                fin_ok      = 1'b1;
              end
            end
            ACT_RIGHT: begin
              if (cur_col_r != LAST_COL) begin
                cur_col_nxt = cur_col_r + 1'b1;
                fin_ok      = 1'b1;
              end
            end
            ACT_SET_POS: begin
              if (tgt_row_ok) begin
                cur_row_nxt = RW'(in_data.target_row);
                if (tgt_col_ok) begin
                  cur_col_nxt = CW'(in_data.target_col);
                  fin_ok      = 1'b1;
                end
              end
            end
            ACT_SHIFT_LEFT: begin
              fin     = 1'b0;
              ptr_nxt = '0;
              rd_addr = AW'(1);
            end
            ACT_READ: begin
              // out-of-range targets answer at once with ok low
              if (tgt_row_ok && tgt_col_ok) begin
                fin     = 1'b0;
                rd_addr = tgt_idx;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_READ: begin
        fin      = 1'b1;
        fin_ok   = 1'b1;
        fin_cell = cell_rd;
      end
      ST_EOL: begin
        mem_we = 1'b1;
        if (ptr_r == eol_end) begin
          fin    = 1'b1;
          fin_ok = 1'b1;
        end else begin
          ptr_nxt = ptr_r + 1'b1;
        end
      end
      ST_SHIFT: begin
        mem_we = 1'b1;
        if (ptr_r == LAST_A) begin
          fin    = 1'b1;
          fin_ok = 1'b1;
        end else begin
          // successor cell was fetched ahead by the registered read
          mem_wd  = cell_rd;
          ptr_nxt = ptr_r + 1'b1;
          rd_addr = (ptr_r >= PRELAST_A) ? LAST_A : ptr_r + AW'(2);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cur_row_r   <= '0;
      cur_col_r   <= '0;
      ptr_r       <= '0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cur_row_r <= cur_row_nxt;
      cur_col_r <= cur_col_nxt;
      ptr_r     <= ptr_nxt;
      if (clr_all) begin
        vld_r <= '0;
      end else if (mem_we) begin
        vld_r[mem_wa] <= 1'b1;
      end
      if (fin) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    mem_rd_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    rd_vld_r <= vld_r[rd_addr];
    if (fin) begin
      out_data_r.ok         <= fin_ok;
      out_data_r.cursor_row <= cur_row_nxt[0];
      out_data_r.cursor_col <= col_field_t'(cur_col_nxt);
      out_data_r.cell_char  <= fin_cell;
    end
  end

endmodule
